### sv/kahp_pkg.sv
// Shared types, codes and defaults for the keypoint angle histogram parser.
package kahp_pkg;

	localparam int KAHP_ANGLE_BINS  = 65536;
	localparam int KAHP_COUNT_WIDTH = 32;

	localparam logic [31:0] RST_EXPECTED_VERSION   = 32'd1;
	localparam logic [15:0] RST_MAX_NAME_LENGTH    = 16'd1000;
	localparam logic [15:0] RST_MAX_PAYLOAD_LENGTH = 16'd50000;

	// minimum payload bytes left for a record to start
	localparam logic [15:0] RECORD_MIN_BYTES = 16'd9;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_READ    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_EXPECTED_VERSION   = 2'd0,
		REG_MAX_NAME_LENGTH    = 2'd1,
		REG_MAX_PAYLOAD_LENGTH = 2'd2,
		REG_UNUSED             = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_BAD_VERSION = 3'd1,
		ERR_NAME_LONG   = 3'd2,
		ERR_PAY_LONG    = 3'd3,
		ERR_OVERRUN     = 3'd4
	} err_t;

	typedef enum logic [5:0] {
		PH_VERSION   = 6'b000001,
		PH_NAME_LEN  = 6'b000010,
		PH_NAME      = 6'b000100,
		PH_PAY_LEN   = 6'b001000,
		PH_RECORD    = 6'b010000,
		PH_CODEWORDS = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [31:0] expected_version;
		logic [15:0] max_name_length;
		logic [15:0] max_payload_length;
	} cfg_t;

	// histogram access issued for one accepted transaction
	typedef struct packed {
		logic        bump;
		logic        rd;
		logic [15:0] addr;
	} hist_req_t;

	typedef struct packed {
		logic       finished;
		logic       halted;
		logic [2:0] error_code;
	} status_t;

	typedef struct packed {
		logic [31:0] bin_count;
		status_t     status;
	} result_t;

endpackage

### sv/kahp_parser.sv
// Byte stream parser: version word, documents, keypoint records and codewords.
module kahp_parser import kahp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  op_t       op,
	input  logic [7:0] data_byte,
	input  logic [15:0] bin_index,
	input  cfg_t      cfg,
	output hist_req_t req,
	output status_t   status
);

	phase_t      phase_q, phase_d;
	logic [1:0]  fld_q, fld_d;
	logic [31:0] acc_q, acc_d;
	logic [15:0] name_left_q, name_left_d;
	logic [15:0] pay_left_q, pay_left_d;
	logic [3:0]  rec_idx_q, rec_idx_d;
	logic [15:0] angle_q, angle_d;
	logic [7:0]  cw_left_q, cw_left_d;
	logic [1:0]  tri_q, tri_d;
	logic        halt_q, halt_d;
	err_t        err_q, err_d;

	logic [31:0] word;
	logic        word_done;
	logic        finished;
	logic        bump;
	logic [16:0] need;
	logic [16:0] avail;
	logic        payload;
	logic        overrun;

	assign word      = {acc_q[23:0], data_byte};
	assign word_done = (fld_q == 2'd3);
	assign need      = 17'(data_byte) * 17'd3;
	assign avail     = {1'b0, pay_left_q} - 17'd1;

	always_comb begin
		phase_d     = phase_q;
		fld_d       = fld_q;
		acc_d       = acc_q;
		name_left_d = name_left_q;
		pay_left_d  = pay_left_q;
		rec_idx_d   = rec_idx_q;
		angle_d     = angle_q;
		cw_left_d   = cw_left_q;
		tri_d       = tri_q;
		halt_d      = halt_q;
		err_d       = err_q;
		finished    = 1'b0;
		bump        = 1'b0;
		payload     = 1'b0;
		overrun     = 1'b0;
		if (op == OP_RESTART) begin
			phase_d     = PH_VERSION;
			fld_d       = 2'd0;
			acc_d       = '0;
			name_left_d = '0;
			pay_left_d  = '0;
			rec_idx_d   = '0;
			angle_d     = '0;
			cw_left_d   = '0;
			tri_d       = '0;
			halt_d      = 1'b0;
			err_d       = ERR_NONE;
		end else if (op == OP_BYTE && !halt_q) begin
			if (phase_q == PH_VERSION || phase_q == PH_NAME_LEN || phase_q == PH_PAY_LEN) begin
				acc_d = word;
				fld_d = fld_q + 2'd1;
				if (word_done) begin
					acc_d = '0;
					fld_d = 2'd0;
				end
			end
			case (phase_q)
				PH_VERSION: begin
					if (word_done) begin
						if (word != cfg.expected_version) begin
							halt_d = 1'b1;
							err_d  = ERR_BAD_VERSION;
						end else begin
							phase_d = PH_NAME_LEN;
						end
					end
				end
				PH_NAME_LEN: begin
					if (word_done) begin
						if (word > {16'd0, cfg.max_name_length}) begin
							halt_d = 1'b1;
							err_d  = ERR_NAME_LONG;
						end else begin
							name_left_d = word[15:0];
							phase_d     = (word[15:0] != '0) ? PH_NAME : PH_PAY_LEN;
						end
					end
				end
				PH_NAME: begin
					name_left_d = name_left_q - 16'd1;
					if (name_left_q == 16'd1) begin
						phase_d = PH_PAY_LEN;
					end
				end
				PH_PAY_LEN: begin
					if (word_done) begin
						if (word > {16'd0, cfg.max_payload_length}) begin
							halt_d = 1'b1;
							err_d  = ERR_PAY_LONG;
						end else begin
							pay_left_d = word[15:0];
							rec_idx_d  = '0;
							phase_d    = (word[15:0] != '0) ? PH_RECORD : PH_NAME_LEN;
						end
					end
				end
				PH_RECORD: begin
					payload = 1'b1;
					if (rec_idx_q == 4'd0 && pay_left_q < RECORD_MIN_BYTES) begin
						// padding byte
					end else if (rec_idx_q == 4'd4) begin
						angle_d   = {data_byte, 8'd0};
						rec_idx_d = rec_idx_q + 4'd1;
					end else if (rec_idx_q == 4'd5) begin
						angle_d   = {angle_q[15:8], data_byte};
						rec_idx_d = rec_idx_q + 4'd1;
					end else if (rec_idx_q == 4'd8) begin
						rec_idx_d = '0;
						if (need > avail) begin
							// record would run past the payload: stop, length untouched
							overrun = 1'b1;
							halt_d  = 1'b1;
							err_d   = ERR_OVERRUN;
						end else if (data_byte == 8'd0) begin
							finished = 1'b1;
						end else begin
							cw_left_d = data_byte;
							tri_d     = '0;
							phase_d   = PH_CODEWORDS;
						end
					end else begin
						rec_idx_d = rec_idx_q + 4'd1;
					end
				end
				PH_CODEWORDS: begin
					payload = 1'b1;
					if (tri_q == 2'd2) begin
						tri_d     = '0;
						bump      = 1'b1;
						cw_left_d = cw_left_q - 8'd1;
						if (cw_left_q == 8'd1) begin
							finished = 1'b1;
							phase_d  = PH_RECORD;
						end
					end else begin
						tri_d = tri_q + 2'd1;
					end
				end
				default: begin
					phase_d = PH_VERSION;
				end
			endcase
			if (payload && !overrun) begin
				pay_left_d = pay_left_q - 16'd1;
				if (pay_left_q == 16'd1) begin
					phase_d   = PH_NAME_LEN;
					rec_idx_d = '0;
					tri_d     = '0;
					cw_left_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_VERSION;
			fld_q       <= '0;
			acc_q       <= '0;
			name_left_q <= '0;
			pay_left_q  <= '0;
			rec_idx_q   <= '0;
			angle_q     <= '0;
			cw_left_q   <= '0;
			tri_q       <= '0;
			halt_q      <= 1'b0;
			err_q       <= ERR_NONE;
		end else if (accept) begin
			phase_q     <= phase_d;
			fld_q       <= fld_d;
			acc_q       <= acc_d;
			name_left_q <= name_left_d;
			pay_left_q  <= pay_left_d;
			rec_idx_q   <= rec_idx_d;
			angle_q     <= angle_d;
			cw_left_q   <= cw_left_d;
			tri_q       <= tri_d;
			halt_q      <= halt_d;
			err_q       <= err_d;
		end
	end

	assign req.bump = bump;
	assign req.rd   = (op == OP_READ);
	assign req.addr = bump ? angle_q : bin_index;

	assign status.finished   = finished;
	assign status.halted     = halt_d;
	assign status.error_code = err_d;

endmodule

### sv/kahp_hist.sv
// Angle histogram memory with clearing pass, read-modify-write and forwarding.
module kahp_hist import kahp_pkg::*; #(
	parameter int ANGLE_BINS  = KAHP_ANGLE_BINS,
	parameter int COUNT_WIDTH = KAHP_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  hist_req_t   req,
	output logic        busy,
	output logic        res_valid,
	output logic [31:0] bin_count
);

	localparam int IDX_W = $clog2(ANGLE_BINS);
	localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
	localparam logic [COUNT_WIDTH-1:0] BIN_TOP = '1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ANGLE_BINS - 1);

	logic [COUNT_WIDTH-1:0] mem [ANGLE_BINS];

	logic                   clr_q;
	logic [IDX_W-1:0]       clr_idx_q;
	logic                   in_range;

	logic                   v_s1;
	logic                   rd_s1;
	logic                   bump_s1;
	logic [IDX_W-1:0]       addr_s1;
	logic [COUNT_WIDTH-1:0] rdata_s1;

	logic                   fwd_v_q;
	logic [IDX_W-1:0]       fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;

	logic [COUNT_WIDTH-1:0] old_val;
	logic [COUNT_WIDTH-1:0] new_val;
	logic                   upd;
	logic [EXT_W-1:0]       ext_val;

	assign in_range = ({1'b0, req.addr} < 17'(ANGLE_BINS));
	assign busy     = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST_IDX) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			rd_s1   <= 1'b0;
			bump_s1 <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			v_s1    <= req_valid;
			rd_s1   <= req_valid && req.rd && in_range;
			bump_s1 <= req_valid && req.bump && in_range;
			fwd_v_q <= upd;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= req.addr[IDX_W-1:0];
		fwd_addr_q <= addr_s1;
		fwd_data_q <= new_val;
	end

	always_ff @(posedge clk) begin
		if (req_valid && (req.rd || req.bump) && in_range) begin
			rdata_s1 <= mem[req.addr[IDX_W-1:0]];
		end
	end

	// a write in the same cycle as the read left the read data stale
	assign old_val = (fwd_v_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata_s1;
	assign upd     = bump_s1 && (old_val != BIN_TOP);
	assign new_val = old_val + COUNT_WIDTH'(1);

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (upd) begin
			mem[addr_s1] <= new_val;
		end
	end

	assign ext_val   = EXT_W'(old_val);
	assign res_valid = v_s1;
	assign bin_count = rd_s1 ? ext_val[31:0] : 32'd0;

	a_no_req_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !req_valid) else $error("transaction accepted during clearing pass");
	a_no_s1_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !v_s1) else $error("histogram stage busy during clearing pass");
	a_fwd_follows_upd: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> fwd_v_q && fwd_data_q != '0) else $error("forwarding register lost update");

endmodule

### sv/kahp_outq.sv
// Two-entry result queue decoupling the pipeline from output stalls.
module kahp_outq import kahp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    not_empty,
	output logic [1:0] count,
	output result_t head
);

	result_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	assign not_empty = (cnt_q != 2'd0);
	assign count     = cnt_q;
	assign head      = ent_q[rd_ptr_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != 2'd2) else $error("result queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0) else $error("result queue underflow");

endmodule

### sv/keypoint_angle_histogram_parser_core.sv
// Keypoint angle histogram parser core: one transaction per cycle while in_stall is low.
// Each accepted transaction (stream byte, bin read, restart) yields one result.
// Parsing runs in registers in the accept cycle; the histogram sits in a
// one-write/one-read memory of ANGLE_BINS entries, read in the accept cycle and
// updated in the cycle after, with forwarding so hits on the same bin in
// consecutive cycles count correctly. Results are registered in the histogram
// stage and pass through a two-entry queue, so the input keeps flowing while a
// result waits. After reset a clearing pass zeroes all ANGLE_BINS bins (65536 by
// default), one bin per cycle; in_stall is held high meanwhile, while
// configuration writes are taken at any time.
module keypoint_angle_histogram_parser_core import kahp_pkg::*; #(
	parameter int ANGLE_BINS  = KAHP_ANGLE_BINS,
	parameter int COUNT_WIDTH = KAHP_COUNT_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	input  logic [15:0] bin_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] bin_count,
	output logic        record_finished,
	output logic        halted,
	output logic [2:0]  error_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t      cfg_q;
	logic      accept;
	logic      pop;
	logic      busy;
	logic      res_valid;
	logic [31:0] res_count;
	logic [1:0] q_count;
	logic [2:0] occ;
	hist_req_t req;
	status_t   status;
	status_t   status_s1;
	result_t   q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version   <= RST_EXPECTED_VERSION;
			cfg_q.max_name_length    <= RST_MAX_NAME_LENGTH;
			cfg_q.max_payload_length <= RST_MAX_PAYLOAD_LENGTH;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_EXPECTED_VERSION:   cfg_q.expected_version   <= cfg_data;
				REG_MAX_NAME_LENGTH:    cfg_q.max_name_length    <= cfg_data[15:0];
				REG_MAX_PAYLOAD_LENGTH: cfg_q.max_payload_length <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// room check counts the result in flight and a pop in this cycle
	assign pop      = out_valid && !out_stall;
	assign occ      = 3'(q_count) + 3'(res_valid) - 3'(pop);
	assign in_stall = busy || (occ >= 3'd2);
	assign accept   = in_valid && !in_stall;

	kahp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op_t'(operation)),
		.data_byte (data_byte),
		.bin_index (bin_index),
		.cfg       (cfg_q),
		.req       (req),
		.status    (status)
	);

	kahp_hist #(
		.ANGLE_BINS  (ANGLE_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (accept),
		.req       (req),
		.busy      (busy),
		.res_valid (res_valid),
		.bin_count (res_count)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
		end
	end

	kahp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data ({res_count, status_s1}),
		.pop       (pop),
		.not_empty (out_valid),
		.count     (q_count),
		.head      (q_head)
	);

	assign bin_count       = q_head.bin_count;
	assign record_finished = q_head.status.finished;
	assign halted          = q_head.status.halted;
	assign error_code      = q_head.status.error_code;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !accept) else $error("transaction accepted while clearing");

endmodule
